[hw/rtl/zorder_block_partition_addresser_assert.svh]
// Assertion helpers for the Z-order block addresser.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ZORDER_BLOCK_PARTITION_ADDRESSER_ASSERT_SVH
`define ZORDER_BLOCK_PARTITION_ADDRESSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZBPA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZBPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/zbpa_pkg.sv]
`default_nettype none

package zbpa_pkg;

  localparam int MAX_DIMS     = 4;
  localparam int CLUSTER_BITS = 4;
  localparam int REG_DIMS     = 4;
  localparam int CODE_BITS    = 64;
  localparam int ND_MAX       = (MAX_DIMS < REG_DIMS) ? MAX_DIMS : REG_DIMS;
  localparam int DIM_W        = $clog2(REG_DIMS);
  // 33-bit dividend for the ceiling division, one quotient bit per step.
  localparam int DIV_STEPS    = 33;
  localparam int CNT_W        = 6;

  typedef logic [DIM_W-1:0] dim_idx_t;

  typedef enum logic [2:0] {
    REG_NUM_DIMS      = 3'd0,
    REG_DIM_SIZE_0    = 3'd1,
    REG_DIM_SIZE_1    = 3'd2,
    REG_DIM_SIZE_2    = 3'd3,
    REG_DIM_SIZE_3    = 3'd4,
    REG_TILE_SIDE     = 3'd5,
    REG_ELEMENT_BYTES = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CFG_WRITE,
    DP_DIV_LOAD,
    DP_DIV_STEP,
    DP_DIV_STORE,
    DP_P_INIT,
    DP_P_LO,
    DP_P_LO_USE,
    DP_P_HI,
    DP_P_HI_USE,
    DP_P_FIN,
    DP_LOAD,
    DP_E_MUL,
    DP_E_USE,
    DP_H_LO,
    DP_H_LO_USE,
    DP_H_HI,
    DP_H_HI_USE,
    DP_B_LO,
    DP_B_LO_USE,
    DP_B_HI,
    DP_B_HI_USE,
    DP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t   op;
    dim_idx_t dim;
  } dp_cmd_t;

  typedef struct packed {
    logic     item_end;
    dim_idx_t nd_last;
    logic     cfg_idx_ok;
  } dp_status_t;

  typedef struct packed {
    logic        op;
    logic [31:0] in_cluster_id;
    logic [15:0] in_block_id;
  } in_item_t;

  typedef struct packed {
    logic        end_flag;
    logic [31:0] out_cluster_id;
    logic [15:0] out_block_id;
    logic [63:0] byte_offset;
    logic [15:0] extent_0;
    logic [15:0] extent_1;
    logic [15:0] extent_2;
    logic [15:0] extent_3;
    logic        at_boundary;
  } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/zorder_block_partition_addresser.sv]
// Z-order block addresser. Each input transaction either steps to the next block of the
// tiled array (op 0) or locates a block from its cluster and block id (op 1), and gives
// one result transaction with the Morton ids, byte offset, clipped extents and edge flag.
// Each item is paced by the single shared 32x32 multiplier: one product per dimension for
// the origin, two per further dimension for the row-major offset, and two for the element
// size. An op 0 issued after the last block goes straight to the result with the end flag.
// A result waiting in the output register does not hold off the next item. After reset,
// and after every configuration write to a listed register, the block counts per dimension
// and the total are rebuilt with a bit-serial divider and the multiplier; while this runs,
// in_stall is high and cfg_ready low.
`default_nettype none

`include "zorder_block_partition_addresser_assert.svh"

module zorder_block_partition_addresser import zbpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  zbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .status    (status)
  );

  zbpa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  `ZBPA_ASSERT_SAME(a_no_dual_accept, in_valid && !in_stall, !(cfg_valid && cfg_ready), "item and configuration accepted together")
  `ZBPA_ASSERT_NEXT(a_busy_after_item, in_valid && !in_stall, !cfg_ready, "configuration port ready while an item is in flight")
  `ZBPA_ASSERT_NEXT(a_rebuild_stalls, cfg_valid && cfg_ready && cfg_index <= REG_ELEMENT_BYTES, in_stall, "input not stalled during rebuild")
  `ZBPA_ASSERT_SAME(a_end_clean, out_valid && out_data.end_flag, out_data.byte_offset == 64'd0 && out_data.out_cluster_id == 32'd0 && !out_data.at_boundary, "end result carries block data")

endmodule

`default_nettype wire

[hw/rtl/zbpa_ctrl.sv]
`default_nettype none

module zbpa_ctrl import zbpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_RB_DIV_LOAD,
    S_RB_DIV_STEP,
    S_RB_DIV_STORE,
    S_RB_PINIT,
    S_RB_PLO,
    S_RB_PLO_USE,
    S_RB_PHI,
    S_RB_PHI_USE,
    S_RB_FIN,
    S_EMUL,
    S_EUSE,
    S_HLO,
    S_HLO_USE,
    S_HHI,
    S_HHI_USE,
    S_BLO,
    S_BLO_USE,
    S_BHI,
    S_BHI_USE,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  dim_idx_t          dim_r, dim_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign cfg_ready = (state_r == S_IDLE);
  // A configuration write takes priority over an item offered in the same cycle.
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    dim_nxt       = dim_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = DP_NOP;
    cmd.dim       = dim_r;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.op = DP_CFG_WRITE;
          if (status.cfg_idx_ok) begin
            state_nxt = S_RB_DIV_LOAD;
            dim_nxt   = '0;
          end
        end else if (in_valid) begin
          cmd.op  = DP_LOAD;
          dim_nxt = '0;
          state_nxt = status.item_end ? S_OUT : S_EMUL;
        end
      end
      S_RB_DIV_LOAD: begin
        cmd.op    = DP_DIV_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_RB_DIV_STEP;
      end
      S_RB_DIV_STEP: begin
        cmd.op  = DP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_RB_DIV_STORE;
        end
      end
      S_RB_DIV_STORE: begin
        cmd.op = DP_DIV_STORE;
        if (dim_r == DIM_W'(REG_DIMS - 1)) begin
          state_nxt = S_RB_PINIT;
          dim_nxt   = '0;
        end else begin
          dim_nxt   = dim_r + 1'b1;
          state_nxt = S_RB_DIV_LOAD;
        end
      end
      S_RB_PINIT: begin
        cmd.op    = DP_P_INIT;
        state_nxt = S_RB_PLO;
      end
      S_RB_PLO: begin
        cmd.op    = DP_P_LO;
        state_nxt = S_RB_PLO_USE;
      end
      S_RB_PLO_USE: begin
        cmd.op    = DP_P_LO_USE;
        state_nxt = S_RB_PHI;
      end
      S_RB_PHI: begin
        cmd.op    = DP_P_HI;
        state_nxt = S_RB_PHI_USE;
      end
      S_RB_PHI_USE: begin
        cmd.op = DP_P_HI_USE;
        if (dim_r == status.nd_last) begin
          state_nxt = S_RB_FIN;
        end else begin
          dim_nxt   = dim_r + 1'b1;
          state_nxt = S_RB_PLO;
        end
      end
      S_RB_FIN: begin
        cmd.op    = DP_P_FIN;
        state_nxt = S_IDLE;
      end
      S_EMUL: begin
        cmd.op    = DP_E_MUL;
        state_nxt = S_EUSE;
      end
      S_EUSE: begin
        cmd.op = DP_E_USE;
        if (dim_r != '0) begin
          state_nxt = S_HLO;
        end else if (status.nd_last == '0) begin
          state_nxt = S_BLO;
        end else begin
          dim_nxt   = dim_r + 1'b1;
          state_nxt = S_EMUL;
        end
      end
      S_HLO: begin
        cmd.op    = DP_H_LO;
        state_nxt = S_HLO_USE;
      end
      S_HLO_USE: begin
        cmd.op    = DP_H_LO_USE;
        state_nxt = S_HHI;
      end
      S_HHI: begin
        cmd.op    = DP_H_HI;
        state_nxt = S_HHI_USE;
      end
      S_HHI_USE: begin
        cmd.op = DP_H_HI_USE;
        if (dim_r == status.nd_last) begin
          state_nxt = S_BLO;
        end else begin
          dim_nxt   = dim_r + 1'b1;
          state_nxt = S_EMUL;
        end
      end
      S_BLO: begin
        cmd.op    = DP_B_LO;
        state_nxt = S_BLO_USE;
      end
      S_BLO_USE: begin
        cmd.op    = DP_B_LO_USE;
        state_nxt = S_BHI;
      end
      S_BHI: begin
        cmd.op    = DP_B_HI;
        state_nxt = S_BHI_USE;
      end
      S_BHI_USE: begin
        cmd.op    = DP_B_HI_USE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // The result register is free once its last transaction has gone.
        if (!out_valid_r || !out_stall) begin
          cmd.op        = DP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RB_DIV_LOAD;
      dim_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dim_r       <= dim_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/zbpa_datapath.sv]
`default_nettype none

module zbpa_datapath import zbpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  in_item_t    in_data,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output out_item_t   out_data
);

  typedef logic [REG_DIMS-1:0][31:0] coord_vec_t;

  logic [2:0]                 num_dims_r;
  coord_vec_t                 dim_size_r;
  logic [15:0]                tile_r;
  logic [12:0]                eb_r;

  coord_vec_t                 bpd_r, coord_r, wc_r;
  logic [63:0]                total_r, prod_r;
  logic                       sat_r, zero_r;
  logic [31:0]                bidx_r;
  logic [CODE_BITS-1:0]       z_r;
  logic [63:0]                acc_r, hold_r, off_r, mul_r;
  logic [47:0]                e_r;
  logic [REG_DIMS-1:0][15:0]  ext_r;
  logic                       bound_r, end_r;
  logic [32:0]                quo_r;
  logic [15:0]                rem_r;
  out_item_t                  out_r;

  logic [2:0]                 nd;
  logic [15:0]                t_eff;
  logic [31:0]                mul_a, mul_b;
  logic [63:0]                mul_p;
  logic [16:0]                trial;
  logic                       div_ge;
  logic [15:0]                div_rem;
  logic [95:0]                pfull;
  logic                       is_last;
  logic [CODE_BITS-1:0]       z_in;
  coord_vec_t                 coord_nxt;

  function automatic logic [CODE_BITS-1:0] interleave(input coord_vec_t c,
                                                      input logic [2:0] n);
    logic [CODE_BITS-1:0] z;
    z = '0;
    for (int nn = 1; nn <= REG_DIMS; nn++) begin
      for (int s = 0; s < 32; s++) begin
        for (int d = 0; d < nn; d++) begin
          if (n == 3'(nn) && (s + 1) * nn <= CODE_BITS) begin
            z[nn * s + d] = c[d][s];
          end
        end
      end
    end
    return z;
  endfunction

  function automatic coord_vec_t deinterleave(input logic [CODE_BITS-1:0] z,
                                              input logic [2:0] n);
    coord_vec_t c;
    c = '0;
    for (int nn = 1; nn <= REG_DIMS; nn++) begin
      for (int s = 0; s < 32; s++) begin
        for (int d = 0; d < nn; d++) begin
          if (n == 3'(nn) && nn * s + d < CODE_BITS) begin
            c[d][s] = z[nn * s + d];
          end
        end
      end
    end
    return c;
  endfunction

  always_comb begin
    if (num_dims_r == 3'd0) begin
      nd = 3'd1;
    end else if (num_dims_r > 3'(ND_MAX)) begin
      nd = 3'(ND_MAX);
    end else begin
      nd = num_dims_r;
    end
  end

  assign t_eff = (tile_r == 16'd0) ? 16'd1 : tile_r;

  assign status.nd_last    = DIM_W'(nd - 3'd1);
  assign status.cfg_idx_ok = (cfg_index <= REG_ELEMENT_BYTES);
  assign status.item_end   = !in_data.op &&
                             (({32'd0, bidx_r} >= total_r) || (bidx_r == 32'hFFFF_FFFF));

  assign z_in = (CODE_BITS'(in_data.in_cluster_id) << CLUSTER_BITS) |
                CODE_BITS'(in_data.in_block_id[CLUSTER_BITS-1:0]);

  // Mixed-radix increment of the block coordinates; dimension 0 never wraps.
  always_comb begin
    logic carry;
    coord_nxt = coord_r;
    carry     = 1'b1;
    for (int d = REG_DIMS - 1; d >= 0; d--) begin
      if (3'(d) < nd && carry) begin
        if (d == 0) begin
          coord_nxt[d] = coord_r[d] + 32'd1;
        end else if (coord_r[d] == bpd_r[d] - 32'd1) begin
          coord_nxt[d] = '0;
        end else begin
          coord_nxt[d] = coord_r[d] + 32'd1;
          carry        = 1'b0;
        end
      end
    end
  end

  // One shared 32 by 32 multiplier, result registered in mul_r.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      DP_P_LO: begin
        mul_a = prod_r[31:0];
        mul_b = bpd_r[cmd.dim];
      end
      DP_P_HI: begin
        mul_a = prod_r[63:32];
        mul_b = bpd_r[cmd.dim];
      end
      DP_E_MUL: begin
        mul_a = wc_r[cmd.dim];
        mul_b = {16'd0, t_eff};
      end
      DP_H_LO: begin
        mul_a = acc_r[31:0];
        mul_b = dim_size_r[cmd.dim];
      end
      DP_H_HI: begin
        mul_a = acc_r[63:32];
        mul_b = dim_size_r[cmd.dim];
      end
      DP_B_LO: begin
        mul_a = acc_r[31:0];
        mul_b = {19'd0, eb_r};
      end
      DP_B_HI: begin
        mul_a = acc_r[63:32];
        mul_b = {19'd0, eb_r};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign trial   = {rem_r, quo_r[32]};
  assign div_ge  = (trial >= {1'b0, t_eff});
  assign div_rem = div_ge ? 16'(trial - {1'b0, t_eff}) : trial[15:0];

  assign pfull   = {mul_r, 32'd0} + {32'd0, hold_r};

  assign is_last = (bpd_r[cmd.dim] != 32'd0) && (wc_r[cmd.dim] == bpd_r[cmd.dim] - 32'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= 3'd2;
      dim_size_r <= {REG_DIMS{32'd1}};
      tile_r     <= 16'd1;
      eb_r       <= 13'd1;
    end else if (cmd.op == DP_CFG_WRITE) begin
      unique case (cfg_index)
        REG_NUM_DIMS:      num_dims_r    <= cfg_data[2:0];
        REG_DIM_SIZE_0:    dim_size_r[0] <= cfg_data;
        REG_DIM_SIZE_1:    dim_size_r[1] <= cfg_data;
        REG_DIM_SIZE_2:    dim_size_r[2] <= cfg_data;
        REG_DIM_SIZE_3:    dim_size_r[3] <= cfg_data;
        REG_TILE_SIDE:     tile_r        <= cfg_data[15:0];
        REG_ELEMENT_BYTES: eb_r          <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_p;
    case (cmd.op) inside
      DP_DIV_LOAD: begin
        quo_r <= {1'b0, dim_size_r[cmd.dim]} + 33'(t_eff) - 33'd1;
        rem_r <= '0;
      end
      DP_DIV_STEP: begin
        quo_r <= {quo_r[31:0], div_ge};
        rem_r <= div_rem;
      end
      DP_DIV_STORE: bpd_r[cmd.dim] <= quo_r[31:0];
      DP_P_INIT: begin
        prod_r  <= 64'd1;
        sat_r   <= 1'b0;
        zero_r  <= 1'b0;
        bidx_r  <= '0;
        coord_r <= '0;
      end
      DP_P_LO_USE, DP_H_LO_USE, DP_B_LO_USE: hold_r <= mul_r;
      DP_P_HI_USE: begin
        // A zero count anywhere wins over saturation.
        if (bpd_r[cmd.dim] == 32'd0) begin
          zero_r <= 1'b1;
        end else if (!sat_r) begin
          if (pfull[95:64] != 32'd0) begin
            sat_r <= 1'b1;
          end else begin
            prod_r <= pfull[63:0];
          end
        end
      end
      DP_P_FIN: total_r <= zero_r ? 64'd0 : (sat_r ? 64'hFFFF_FFFF_FFFF_FFFF : prod_r);
      DP_LOAD: begin
        ext_r   <= '0;
        bound_r <= 1'b0;
        end_r   <= status.item_end;
        if (in_data.op) begin
          z_r  <= z_in;
          wc_r <= deinterleave(z_in, nd);
        end else begin
          z_r  <= interleave(coord_r, nd);
          wc_r <= coord_r;
          if (!status.item_end) begin
            coord_r <= coord_nxt;
            bidx_r  <= bidx_r + 32'd1;
          end
        end
      end
      DP_E_USE: begin
        if (cmd.dim == '0) begin
          acc_r <= {16'd0, mul_r[47:0]};
        end else begin
          e_r <= mul_r[47:0];
        end
        // On the last block, origin times tile equals (blocks - 1) times tile.
        ext_r[cmd.dim] <= is_last ? (dim_size_r[cmd.dim][15:0] - mul_r[15:0]) : t_eff;
        if (is_last) begin
          bound_r <= 1'b1;
        end
      end
      DP_H_HI_USE: acc_r <= hold_r + {mul_r[31:0], 32'd0} + {16'd0, e_r};
      DP_B_HI_USE: off_r <= hold_r + {mul_r[31:0], 32'd0};
      DP_OUT_LOAD: begin
        if (end_r) begin
          // The end flag is the top bit of the result; every other field is zero.
          out_r <= {1'b1, {($bits(out_item_t) - 1){1'b0}}};
        end else begin
          out_r.end_flag       <= 1'b0;
          out_r.out_cluster_id <= z_r[CLUSTER_BITS+31:CLUSTER_BITS];
          out_r.out_block_id   <= 16'(z_r[CLUSTER_BITS-1:0]);
          out_r.byte_offset    <= off_r;
          out_r.extent_0       <= ext_r[0];
          out_r.extent_1       <= ext_r[1];
          out_r.extent_2       <= ext_r[2];
          out_r.extent_3       <= ext_r[3];
          out_r.at_boundary    <= bound_r;
        end
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[tb/zorder_block_partition_addresser_tb.sv]
`default_nettype none

module zorder_block_partition_addresser_tb;
  import zbpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  zorder_block_partition_addresser DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block's configuration and counters.
  logic [2:0]  sh_dims;
  logic [31:0] sh_size [4];
  logic [15:0] sh_tile;
  logic [12:0] sh_ebytes;
  logic [31:0] sh_index;
  logic [31:0] sh_bpd [4];
  logic [63:0] sh_total;

  out_item_t addr_pending[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  bit quiet = 1'b0;

  function automatic int dims_used();
    int n;
    n = sh_dims;
    if (n < 1) n = 1;
    if (n > ND_MAX) n = ND_MAX;
    return n;
  endfunction

  function automatic logic [63:0] tile_eff();
    return (sh_tile == 0) ? 64'd1 : {48'd0, sh_tile};
  endfunction

  function automatic void rebuild_counts();
    int n;
    logic [63:0] t, prod, b;
    bit sat;
    n = dims_used();
    t = tile_eff();
    prod = 64'd1;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) sh_bpd[i] = 32'(({32'd0, sh_size[i]} + t - 1) / t);
    for (int i = 0; i < n; i++) begin
      b = {32'd0, sh_bpd[i]};
      if (b == 0) begin
        prod = 0;
        sat = 1'b0;
        break;
      end
      if (!sat && prod > 64'hFFFF_FFFF_FFFF_FFFF / b) sat = 1'b1;
      else if (!sat) prod = prod * b;
    end
    sh_total = sat ? 64'hFFFF_FFFF_FFFF_FFFF : prod;
    sh_index = 0;
  endfunction

  function automatic out_item_t predict_block(in_item_t it);
    out_item_t r;
    int n, nbits;
    logic [31:0] c [4];
    logic [63:0] z, idx, t, id, acc, ext;
    logic [63:0] e [4];
    logic [15:0] ex [4];
    bit bound, last;
    r = '0;
    n = dims_used();
    t = tile_eff();
    for (int i = 0; i < 4; i++) begin
      c[i] = 0;
      ex[i] = 0;
      e[i] = 0;
    end
    z = 0;
    if (it.op == 1'b0) begin
      idx = {32'd0, sh_index};
      if (idx >= sh_total || sh_index == 32'hFFFF_FFFF) begin
        r.end_flag = 1'b1;
        return r;
      end
      for (int i = n - 1; i > 0; i--) begin
        c[i] = 32'(idx % sh_bpd[i]);
        idx = idx / sh_bpd[i];
      end
      c[0] = idx[31:0];
      nbits = 64 / n;
      for (int i = 0; i < nbits && i < 32; i++)
        for (int d = 0; d < n; d++)
          if (c[d][i]) z[n * i + d] = 1'b1;
      sh_index++;
    end else begin
      z = ({32'd0, it.in_cluster_id} << CLUSTER_BITS) |
          {60'd0, it.in_block_id[CLUSTER_BITS-1:0]};
      for (int i = 0; i < 64; i++)
        if ((i / n) < 32 && z[i]) c[i % n][i / n] = 1'b1;
    end
    r.out_cluster_id = z[CLUSTER_BITS +: 32];
    r.out_block_id = {12'd0, z[CLUSTER_BITS-1:0]};
    bound = 1'b0;
    for (int i = 0; i < n; i++) begin
      last = sh_bpd[i] != 0 && c[i] == sh_bpd[i] - 1;
      ext = t;
      e[i] = {32'd0, c[i]} * t;
      if (last) begin
        bound = 1'b1;
        ext = {32'd0, sh_size[i]} - {32'd0, sh_bpd[i] - 32'd1} * t;
      end
      ex[i] = ext[15:0];
    end
    id = e[n - 1];
    acc = 64'd1;
    for (int i = n - 1; i > 0; i--) begin
      acc = acc * {32'd0, sh_size[i]};
      id = id + acc * e[i - 1];
    end
    r.byte_offset = id * {51'd0, sh_ebytes};
    r.extent_0 = ex[0];
    r.extent_1 = ex[1];
    r.extent_2 = ex[2];
    r.extent_3 = ex[3];
    r.at_boundary = bound;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("ERROR at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 14);
  endfunction

  // Result checker and receiver-side stalling.
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (addr_pending.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        w = addr_pending.pop_front();
        if (out_data.end_flag !== w.end_flag)
          report_mismatch("end_flag", out_data.end_flag, w.end_flag);
        if (out_data.out_cluster_id !== w.out_cluster_id)
          report_mismatch("out_cluster_id", out_data.out_cluster_id, w.out_cluster_id);
        if (out_data.out_block_id !== w.out_block_id)
          report_mismatch("out_block_id", out_data.out_block_id, w.out_block_id);
        if (out_data.byte_offset !== w.byte_offset)
          report_mismatch("byte_offset", out_data.byte_offset, w.byte_offset);
        if (out_data.extent_0 !== w.extent_0)
          report_mismatch("extent_0", out_data.extent_0, w.extent_0);
        if (out_data.extent_1 !== w.extent_1)
          report_mismatch("extent_1", out_data.extent_1, w.extent_1);
        if (out_data.extent_2 !== w.extent_2)
          report_mismatch("extent_2", out_data.extent_2, w.extent_2);
        if (out_data.extent_3 !== w.extent_3)
          report_mismatch("extent_3", out_data.extent_3, w.extent_3);
        if (out_data.at_boundary !== w.at_boundary)
          report_mismatch("at_boundary", out_data.at_boundary, w.at_boundary);
      end
      results_seen++;
    end
    out_stall <= idle_now();
  end

  // Valid stays high after acceptance until the next call or drain changes it, so that
  // back-to-back calls never assign it twice in one time step.
  task automatic send_item(logic op, logic [31:0] cid, logic [15:0] bid);
    in_item_t it;
    it.op = op;
    it.in_cluster_id = cid;
    it.in_block_id = bid;
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    addr_pending.push_back(predict_block(it));
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (addr_pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    case (idx)
      REG_NUM_DIMS:      sh_dims = val[2:0];
      REG_DIM_SIZE_0:    sh_size[0] = val;
      REG_DIM_SIZE_1:    sh_size[1] = val;
      REG_DIM_SIZE_2:    sh_size[2] = val;
      REG_DIM_SIZE_3:    sh_size[3] = val;
      REG_TILE_SIDE:     sh_tile = val[15:0];
      REG_ELEMENT_BYTES: sh_ebytes = val[12:0];
      default: ;
    endcase
    rebuild_counts();
  endtask

  task automatic setup(logic [2:0] nd, logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                       logic [31:0] s3, logic [15:0] ts, logic [12:0] eb);
    drain();
    write_reg(REG_NUM_DIMS, {29'd0, nd});
    write_reg(REG_DIM_SIZE_0, s0);
    write_reg(REG_DIM_SIZE_1, s1);
    write_reg(REG_DIM_SIZE_2, s2);
    write_reg(REG_DIM_SIZE_3, s3);
    write_reg(REG_TILE_SIDE, {16'd0, ts});
    write_reg(REG_ELEMENT_BYTES, {19'd0, eb});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(1'b0, 0, 0);
    send_item(1'b0, 0, 0);
    send_item(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_directed_walk();
    // Small 2-D grid with clipped edges, walked past its end.
    setup(3'd2, 5, 7, 1, 1, 3, 4);
    for (int i = 0; i < 8; i++) send_item(1'b0, 0, 0);
    send_item(1'b1, 0, 16'hFFF0);
    send_item(1'b1, 32'h1, 16'h3);
    // Zero dimension count and zero tile side behave as one.
    setup(3'd0, 3, 1, 1, 1, 0, 13'h1FFF);
    for (int i = 0; i < 5; i++) send_item(1'b0, 0, 0);
    // A zero extent ends at once; a count above the maximum saturates.
    setup(3'd7, 4, 0, 4, 4, 2, 1);
    send_item(1'b0, 0, 0);
    send_item(1'b1, 32'hDEAD_BEEF, 16'h5A5A);
    // Widest sizes and tile, element size with only its top bit set.
    setup(3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
          13'd4096);
    send_item(1'b0, 0, 0);
    send_item(1'b0, 0, 0);
    send_item(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(1'b1, 32'h8000_0000, 16'h0001);
  endtask

  task automatic test_random_phases();
    logic [31:0] sz [4];
    logic [2:0] nd;
    logic [15:0] ts;
    int walk;
    for (int ph = 0; ph < 24; ph++) begin
      nd = 3'($urandom_range(7));
      for (int i = 0; i < 4; i++)
        case ($urandom_range(3))
          0: sz[i] = $urandom_range(1, 9);
          1: sz[i] = $urandom_range(0, 200);
          2: sz[i] = $urandom;
          default: sz[i] = 32'hFFFF_FFFF - $urandom_range(3);
        endcase
      ts = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
      setup(nd, sz[0], sz[1], sz[2], sz[3], ts, 13'($urandom));
      quiet = (ph == 10);
      walk = $urandom_range(20, 70);
      for (int k = 0; k < walk; k++) begin
        if ($urandom_range(3) == 0)
          send_item(1'b1, ($urandom_range(1) ? $urandom : $urandom_range(0, 40)),
                    16'($urandom));
        else
          send_item(1'b0, $urandom, 16'($urandom));
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    sh_dims = 3'd2;
    for (int i = 0; i < 4; i++) sh_size[i] = 1;
    sh_tile = 1;
    sh_ebytes = 1;
    rebuild_counts();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_walk();
    test_random_phases();
    drain();
    $display("Covered %0d items, %0d results, %0d register writes over 28 settings.",
             items_sent, results_seen, cfg_writes);
    if (errors == 0) $display("zorder_block_partition_addresser: match");
    else $display("zorder_block_partition_addresser: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("zorder_block_partition_addresser: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/zbpa_pkg.sv
hw/rtl/zbpa_ctrl.sv
hw/rtl/zbpa_datapath.sv
hw/rtl/zorder_block_partition_addresser.sv
tb/zorder_block_partition_addresser_tb.sv
